// ----- hw/rtl/csvt_pkg.sv -----
// Shared types and constants for the CSV field tokenizer.
package csvt_pkg;

  localparam int POS_W   = 32;
  localparam int MAX_RES = 3;
  localparam int QDEPTH  = 4;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef enum logic [2:0] {
    K_BYTE = 3'd0,
    K_FEND = 3'd1,
    K_REND = 3'd2,
    K_IEND = 3'd3,
    K_ERR  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    E_QUOTE_UNQUOTED = 2'd0,
    E_END_IN_QUOTES  = 2'd1,
    E_AFTER_QUOTE    = 2'd2
  } err_t;

  // Every result caused by one accepted byte or end mark.
  typedef struct packed {
    logic [1:0]                count;
    kind_t [MAX_RES-1:0]       kinds;
    logic [7:0]                data;
    err_t                      err;
    logic [POS_W-1:0]          pos;
  } res_bundle_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// ----- hw/rtl/csvt_lexer.sv -----
// Front end: accepts bytes, runs the lexer state and builds result bundles.
module csvt_lexer
  import csvt_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        in_is_end,
  output logic        q_push,
  output res_bundle_t q_data
);

  typedef enum logic [2:0] {
    M_START    = 3'd0,
    M_FIELD    = 3'd1,
    M_QUOTED   = 3'd2,
    M_QSEEN    = 3'd3,
    M_AFTERQ   = 3'd4,
    M_ROWSTART = 3'd5,
    M_DONE     = 3'd6
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic [POS_W-1:0]       pos_sat;
  logic                   adv;

  generate
    if (OFFSET_BITS > POS_W) begin : g_sat
      assign pos_sat = (|offset_r[OFFSET_BITS-1:POS_W]) ? '1 : offset_r[POS_W-1:0];
    end else begin : g_ext
      assign pos_sat = POS_W'(offset_r);
    end
  endgenerate

  always_comb begin
    logic [1:0] cnt;
    logic       delim;
    logic       is_quote;
    logic       is_sep;
    cnt      = 2'd0;
    delim    = 1'b0;
    adv      = 1'b0;
    is_quote = (in_byte == CH_QUOTE);
    is_sep   = (in_byte == CH_COMMA) || (in_byte == CH_NL);
    mode_nxt = mode_r;
    q_data   = '0;
    q_data.data = in_byte;
    q_data.pos  = pos_sat;
    for (int i = 0; i < MAX_RES; i++) begin
      q_data.kinds[i] = K_BYTE;
    end

    case (mode_r)
      M_START, M_ROWSTART: begin
        if (in_is_end) begin
          if (mode_r != M_ROWSTART) begin
            q_data.kinds[cnt] = K_FEND;
            cnt = cnt + 2'd1;
          end
          q_data.kinds[cnt] = K_IEND;
          cnt = cnt + 2'd1;
          mode_nxt = M_DONE;
        end else begin
          adv = 1'b1;
          if (is_quote) begin
            mode_nxt = M_QUOTED;
          end else if (is_sep) begin
            delim = 1'b1;
          end else begin
            q_data.kinds[cnt] = K_BYTE;
            cnt = cnt + 2'd1;
            mode_nxt = M_FIELD;
          end
        end
      end
      M_FIELD: begin
        if (in_is_end) begin
          q_data.kinds[0] = K_FEND;
          q_data.kinds[1] = K_IEND;
          cnt = 2'd2;
          mode_nxt = M_DONE;
        end else begin
          adv = 1'b1;
          if (is_sep) begin
            delim = 1'b1;
          end else if (is_quote) begin
            q_data.kinds[0] = K_ERR;
            q_data.err = E_QUOTE_UNQUOTED;
            cnt = 2'd1;
          end else begin
            q_data.kinds[0] = K_BYTE;
            cnt = 2'd1;
          end
        end
      end
      M_QUOTED: begin
        if (in_is_end) begin
          q_data.kinds[0] = K_ERR;
          q_data.kinds[1] = K_FEND;
          q_data.kinds[2] = K_IEND;
          q_data.err = E_END_IN_QUOTES;
          cnt = 2'd3;
          mode_nxt = M_DONE;
        end else begin
          adv = 1'b1;
          if (is_quote) begin
            mode_nxt = M_QSEEN;
          end else begin
            q_data.kinds[0] = K_BYTE;
            cnt = 2'd1;
          end
        end
      end
      M_QSEEN, M_AFTERQ: begin
        if (in_is_end) begin
          q_data.kinds[0] = K_FEND;
          q_data.kinds[1] = K_IEND;
          cnt = 2'd2;
          mode_nxt = M_DONE;
        end else begin
          adv = 1'b1;
          if (mode_r == M_QSEEN && is_quote) begin
            // doubled quote: one literal quote
            q_data.kinds[0] = K_BYTE;
            cnt = 2'd1;
            mode_nxt = M_QUOTED;
          end else if (is_sep) begin
            delim = 1'b1;
          end else begin
            q_data.kinds[0] = K_ERR;
            q_data.err = E_AFTER_QUOTE;
            cnt = 2'd1;
            mode_nxt = M_AFTERQ;
          end
        end
      end
      default: begin
        // input has ended: report it again, hold the offset
        q_data.kinds[0] = K_IEND;
        cnt = 2'd1;
        mode_nxt = M_DONE;
      end
    endcase

    if (delim) begin
      q_data.kinds[cnt] = K_FEND;
      cnt = cnt + 2'd1;
      if (in_byte == CH_NL) begin
        q_data.kinds[cnt] = K_REND;
        cnt = cnt + 2'd1;
        mode_nxt = M_ROWSTART;
      end else begin
        mode_nxt = M_START;
      end
    end

    q_data.count = cnt;
  end

  assign q_push = accept && (q_data.count != 2'd0);

  always_comb begin
    offset_nxt = offset_r;
    if (accept && adv && (offset_r != '1)) begin
      offset_nxt = offset_r + OFFSET_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_START;
      offset_r <= '0;
    end else begin
      if (accept) begin
        mode_r <= mode_nxt;
      end
      offset_r <= offset_nxt;
    end
  end

endmodule

// ----- hw/rtl/csvt_queue.sv -----
// Short queue of result bundles between the lexer and the emitter.
module csvt_queue
  import csvt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  res_bundle_t wr_data,
  input  logic        pop,
  output res_bundle_t rd_data,
  output q_stat_t     stat
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  res_bundle_t        slots_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push, do_pop;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(QDEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/csvt_emitter.sv -----
// Back end: steps through the results of the oldest bundle, one per transaction.
module csvt_emitter
  import csvt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  res_bundle_t        head,
  input  q_stat_t            stat,
  input  logic               out_pop,
  output logic               q_pop,
  output logic               out_empty,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_data_byte,
  output logic [1:0]         out_error_code,
  output logic [POS_W-1:0]   out_position,
  output logic               out_last
);

  logic [1:0] idx_r, idx_nxt;
  kind_t      cur_kind;
  logic       taken;

  assign cur_kind       = head.kinds[idx_r];
  assign out_empty      = stat.empty;
  assign out_kind       = cur_kind;
  assign out_data_byte  = (cur_kind == K_BYTE) ? head.data : 8'd0;
  assign out_error_code = (cur_kind == K_ERR) ? head.err : 2'd0;
  assign out_position   = head.pos;
  assign out_last       = (idx_r == head.count - 2'd1);

  assign taken = out_pop && !stat.empty;
  assign q_pop = taken && out_last;

  always_comb begin
    idx_nxt = idx_r;
    if (taken) begin
      idx_nxt = out_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// ----- hw/rtl/csv_field_tokenizer.sv -----
// Top level of the CSV field tokenizer: lexer, bundle queue and emitter.
//
//   channel  direction  handshake       payload
//   in_      in         in_push/in_full in_byte, in_is_end
//   out_     out        out_pop/out_empty out_kind, out_data_byte, out_error_code,
//                                      out_position, out_last
//
// One byte or end mark is taken per cycle while the queue has room; the lexer
// state updates in that same cycle. The emitter hands out one result per transaction,
// so items with two or three results (field end with row end, end of input)
// take that many output transactions, absorbed by the four-entry bundle queue.
// Items that cause no result (an opening quote, the first of a quote pair)
// never enter the queue. Reset is synchronous and empties the queue.
module csv_field_tokenizer
  import csvt_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_byte,
  input  logic               in_is_end,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_data_byte,
  output logic [1:0]         out_error_code,
  output logic [POS_W-1:0]   out_position,
  output logic               out_last
);

  res_bundle_t wr_bundle, head;
  q_stat_t     stat;
  logic        accept, q_push, q_pop;

  assign in_full = stat.full;
  assign accept  = in_push && !stat.full;

  csvt_lexer #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_is_end (in_is_end),
    .q_push    (q_push),
    .q_data    (wr_bundle)
  );

  csvt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (wr_bundle),
    .pop     (q_pop),
    .rd_data (head),
    .stat    (stat)
  );

  csvt_emitter u_emitter (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .stat           (stat),
    .out_pop        (out_pop),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_error_code (out_error_code),
    .out_position   (out_position),
    .out_last       (out_last)
  );

endmodule

// ----- tb/sv/csv_field_tokenizer_test.sv -----
// Self-checking testbench for the CSV field tokenizer: random CSV text, token prediction.
module csv_field_tokenizer_test
  import csvt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 400;
  localparam int STALL_AFTER   = 150;
  localparam int STALL_CYCLES  = 200;
  localparam int DRAIN_CYCLES  = 20;
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic [2:0] {
    LX_START    = 3'd0,
    LX_FIELD    = 3'd1,
    LX_QUOTED   = 3'd2,
    LX_QSEEN    = 3'd3,
    LX_AFTERQ   = 3'd4,
    LX_ROWSTART = 3'd5,
    LX_DONE     = 3'd6
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_end;
  } csv_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic [1:0]       err;
    logic [POS_W-1:0] pos;
    logic             last;
  } csv_token_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  logic             in_full;
  logic [7:0]       in_byte = 8'h00;
  logic             in_is_end = 1'b0;
  logic             out_empty;
  logic             out_pop = 1'b0;
  logic [2:0]       out_kind;
  logic [7:0]       out_data_byte;
  logic [1:0]       out_error_code;
  logic [POS_W-1:0] out_position;
  logic             out_last;

  csv_item_t  csv_text[$];
  csv_token_t tokens_due[$];

  lex_mode_t        lex_mode = LX_START;
  logic [POS_W-1:0] lex_offset = '0;

  int accepted_count = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b1;
  int stall_left = 0;
  bit stall_done = 1'b0;

  csv_field_tokenizer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_byte        (in_byte),
    .in_is_end      (in_is_end),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_error_code (out_error_code),
    .out_position   (out_position),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add_token(kind_t k, logic [7:0] d, logic [1:0] e);
    csv_token_t t;
    t.kind = k;
    t.data = d;
    t.err  = e;
    t.pos  = lex_offset;
    t.last = 1'b0;
    tokens_due.push_back(t);
  endfunction

  // Work out the tokens of one accepted byte or end mark and advance the lexer.
  function automatic void predict_tokens(logic [7:0] c, logic is_end);
    int        n_prior;
    lex_mode_t next;
    logic      delim;
    n_prior = tokens_due.size();
    next    = lex_mode;
    delim   = 1'b0;
    if (lex_mode == LX_DONE) begin
      add_token(K_IEND, '0, '0);
    end else if (is_end) begin
      if (lex_mode == LX_QUOTED) add_token(K_ERR, '0, E_END_IN_QUOTES);
      if (lex_mode != LX_ROWSTART) add_token(K_FEND, '0, '0);
      add_token(K_IEND, '0, '0);
      next = LX_DONE;
    end else begin
      case (lex_mode)
        LX_START, LX_ROWSTART: begin
          if (c == CH_QUOTE) next = LX_QUOTED;
          else if (c == CH_COMMA || c == CH_NL) delim = 1'b1;
          else begin
            add_token(K_BYTE, c, '0);
            next = LX_FIELD;
          end
        end
        LX_FIELD: begin
          if (c == CH_COMMA || c == CH_NL) delim = 1'b1;
          else if (c == CH_QUOTE) add_token(K_ERR, '0, E_QUOTE_UNQUOTED);
          else add_token(K_BYTE, c, '0);
        end
        LX_QUOTED: begin
          if (c == CH_QUOTE) next = LX_QSEEN;
          else add_token(K_BYTE, c, '0);
        end
        default: begin
          if (lex_mode == LX_QSEEN && c == CH_QUOTE) begin
            add_token(K_BYTE, c, '0);
            next = LX_QUOTED;
          end else if (c == CH_COMMA || c == CH_NL) begin
            delim = 1'b1;
          end else begin
            add_token(K_ERR, '0, E_AFTER_QUOTE);
            next = LX_AFTERQ;
          end
        end
      endcase
      if (delim) begin
        add_token(K_FEND, '0, '0);
        if (c == CH_NL) begin
          add_token(K_REND, '0, '0);
          next = LX_ROWSTART;
        end else begin
          next = LX_START;
        end
      end
      if (lex_offset != '1) lex_offset = lex_offset + POS_W'(1);
    end
    lex_mode = next;
    if (tokens_due.size() > n_prior) tokens_due[tokens_due.size()-1].last = 1'b1;
  endfunction

  function automatic void push_byte(logic [7:0] c);
    csv_item_t it;
    it.data   = c;
    it.is_end = 1'b0;
    csv_text.push_back(it);
  endfunction

  function automatic void push_end(logic [7:0] junk);
    csv_item_t it;
    it.data   = junk;
    it.is_end = 1'b1;
    csv_text.push_back(it);
  endfunction

  // Any byte that is not a comma, quote or newline.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 1) begin
      c = 8'h61 + 8'($urandom_range(0, 25));
    end else begin
      c = 8'($urandom_range(0, 255));
      if (c == CH_COMMA || c == CH_QUOTE || c == CH_NL) c = 8'h7A;
    end
    return c;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: present the oldest pending item, predict on each transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_push && !in_full) begin
        predict_tokens(in_byte, in_is_end);
        void'(csv_text.pop_front());
        accepted_count <= accepted_count + 1;
        if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : idle_len();
      end
      if (send_gap > 0) begin
        send_gap--;
        in_push <= 1'b0;
      end else if (csv_text.size() > 0) begin
        in_push   <= 1'b1;
        in_byte   <= csv_text[0].data;
        in_is_end <= csv_text[0].is_end;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Hold the result side off once for a long stretch so the input backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && accepted_count >= STALL_AFTER) begin
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Monitor: check each result transaction against the oldest expected token.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (tokens_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected token kind=%0d data=%02h err=%0d pos=%0d last=%0b",
                     $realtime, out_kind, out_data_byte, out_error_code, out_position,
                     out_last);
        end else begin
          csv_token_t want;
          want = tokens_due.pop_front();
          if (out_kind !== want.kind || out_data_byte !== want.data ||
              out_error_code !== want.err || out_position !== want.pos ||
              out_last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display({"%0t: token mismatch: expected kind=%0d data=%02h err=%0d ",
                        "pos=%0d last=%0b, got kind=%0d data=%02h err=%0d pos=%0d ",
                        "last=%0b"},
                       $realtime, want.kind, want.data, want.err, want.pos, want.last,
                       out_kind, out_data_byte, out_error_code, out_position, out_last);
          end
        end
      end
      if (stall_left > 0) begin
        out_pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
        recv_gap = recv_calm ? 0 : idle_len();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int target;
    int len;
    int r;
    // Empty fields at the start, extreme bytes, a stray quote.
    push_byte(CH_COMMA);
    push_byte(CH_NL);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_COMMA);
    push_byte(8'h61);
    push_byte(CH_QUOTE);
    push_byte(8'h62);
    push_byte(CH_NL);
    // Quoted field with a doubled quote, a comma and a newline inside,
    // then junk after the closing quote.
    push_byte(CH_QUOTE);
    push_byte(8'h78);
    push_byte(CH_QUOTE);
    push_byte(CH_QUOTE);
    push_byte(CH_COMMA);
    push_byte(CH_NL);
    push_byte(CH_QUOTE);
    push_byte(8'h79);
    push_byte(8'h7A);
    push_byte(CH_COMMA);
    // Empty quoted field.
    push_byte(CH_QUOTE);
    push_byte(CH_QUOTE);
    push_byte(CH_COMMA);

    target = csv_text.size() + RANDOM_ITEMS;
    while (csv_text.size() < target) begin
      if ($urandom_range(0, 99) < 75) begin
        len = $urandom_range(0, 6);
        if ($urandom_range(0, 1) == 1) begin
          push_byte(CH_QUOTE);
          repeat (len) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
              push_byte(CH_QUOTE);
              push_byte(CH_QUOTE);
            end else if (r == 1) begin
              push_byte(CH_COMMA);
            end else if (r == 2) begin
              push_byte(CH_NL);
            end else begin
              push_byte(plain_char());
            end
          end
          push_byte(CH_QUOTE);
        end else begin
          repeat (len) push_byte(plain_char());
        end
        push_byte(($urandom_range(0, 3) == 0) ? CH_NL : CH_COMMA);
      end else begin
        // Noise: stray quotes and delimiters among arbitrary bytes.
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 3))
            0:       push_byte(CH_QUOTE);
            1:       push_byte(CH_COMMA);
            2:       push_byte(CH_NL);
            default: push_byte(8'($urandom_range(0, 255)));
          endcase
        end
      end
    end

    // Close the text in one of the states an end mark treats differently.
    case ($urandom_range(0, 4))
      0: push_byte(plain_char());
      1: push_byte(CH_COMMA);
      2: push_byte(CH_NL);
      3: begin
        push_byte(CH_QUOTE);
        push_byte(plain_char());
      end
      default: begin
        push_byte(CH_QUOTE);
        push_byte(plain_char());
        push_byte(CH_QUOTE);
      end
    endcase
    push_end(8'($urandom_range(0, 255)));
    // Items after the end mark only repeat input end.
    push_byte(CH_QUOTE);
    push_byte(8'($urandom_range(0, 255)));
    push_end(8'($urandom_range(0, 255)));
    push_byte(CH_NL);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (csv_text.size() != 0 || tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && tokens_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
